// ===== hw/rtl/bpc_pkg.sv =====
package bpc_pkg;

    // Field widths
    localparam int RAW_W   = 24;
    localparam int CAL_W   = 16;
    localparam int TEMP_W  = 19;
    localparam int PRESS_W = 24;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = CAL_W;

    localparam logic [CFG_IDX_W-1:0] CAL_PRESSURE_SENSITIVITY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CAL_PRESSURE_OFFSET        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CAL_SENSITIVITY_TEMP_COEFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CAL_OFFSET_TEMP_COEFF      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CAL_REFERENCE_TEMP         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CAL_TEMP_COEFF             = 3'd5;

    // Internal datapath widths
    localparam int DT_W   = 25;   // raw temperature minus reference
    localparam int TPR_W  = 41;   // dT times a 16-bit coefficient
    localparam int OFF_W  = 35;
    localparam int SENS_W = 34;
    localparam int PP_W   = 46;   // 12-bit slice of raw pressure times sens
    localparam int SUM_W  = 58;   // raw pressure times sens
    localparam int DIFF_W = 38;
    localparam int HALF_W = 12;

    localparam int STAGES = 6;

    localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;

endpackage

// ===== hw/rtl/bpc_in_if.sv =====
interface bpc_in_if
    import bpc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;

    modport source (output valid, output raw_pressure, output raw_temperature, input ready);
    modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

// ===== hw/rtl/bpc_out_if.sv =====
interface bpc_out_if
    import bpc_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic signed [TEMP_W-1:0]  temperature_centi;
    logic signed [PRESS_W-1:0] pressure_pascal;

    modport source (output valid, output temperature_centi, output pressure_pascal, input ready);
    modport sink   (input valid, input temperature_centi, input pressure_pascal, output ready);
endinterface

// ===== hw/rtl/barometric_pressure_compensation.sv =====
// First-order barometric compensation.
// i_pair carries one raw pressure / raw temperature reading pair per transfer;
// o_result returns the temperature in 0.01 degC and the pressure in Pa.
// Six 16-bit calibration words are written through i_cfg_we / i_cfg_idx /
// i_cfg_data (index 0..5, higher indexes ignored); the user must write them
// only while the block is idle, which the block itself does not enforce.
// An input pair passes the six register stages (dT, three coefficient
// products, offset/sens, two split pressure products, their sum, final shift)
// and the widest multiplier is 25x17 or 13x34 bits. Throughput: one pair per
// cycle, except while all stages are full and o_result.ready is low.
// Every stage has its own valid bit and advances when the stage after it is
// empty or moving, so bubbles are squeezed out and input is still taken while
// a finished result waits at the output. When o_result.ready is low the
// output register holds; i_pair.ready drops only once all six stages are full.
// Reset clears the valid bits and all calibration words to zero.
module barometric_pressure_compensation
    import bpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    bpc_in_if.sink                i_pair,
    bpc_out_if.source             o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // Calibration words
    logic [CAL_W-1:0] r_cal_psens;
    logic [CAL_W-1:0] r_cal_poff;
    logic [CAL_W-1:0] r_cal_scoef;
    logic [CAL_W-1:0] r_cal_ocoef;
    logic [CAL_W-1:0] r_cal_tref;
    logic [CAL_W-1:0] r_cal_tcoef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_psens <= '0;
            r_cal_poff  <= '0;
            r_cal_scoef <= '0;
            r_cal_ocoef <= '0;
            r_cal_tref  <= '0;
            r_cal_tcoef <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CAL_PRESSURE_SENSITIVITY:   r_cal_psens <= i_cfg_data;
                CAL_PRESSURE_OFFSET:        r_cal_poff  <= i_cfg_data;
                CAL_SENSITIVITY_TEMP_COEFF: r_cal_scoef <= i_cfg_data;
                CAL_OFFSET_TEMP_COEFF:      r_cal_ocoef <= i_cfg_data;
                CAL_REFERENCE_TEMP:         r_cal_tref  <= i_cfg_data;
                CAL_TEMP_COEFF:             r_cal_tcoef <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage control: a stage loads when it is empty or its content moves on
    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] w_en;

    always_comb begin
        w_en[STAGES-1] = !r_v[STAGES-1] || o_result.ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign i_pair.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_pair.valid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 0: temperature difference
    logic signed [DT_W-1:0] w_dt;
    logic signed [DT_W-1:0] r_dt;
    logic [RAW_W-1:0]       r_d1_0;

    assign w_dt = $signed({1'b0, i_pair.raw_temperature})
                - $signed({1'b0, r_cal_tref, 8'b0});

    // Stage 1: dT times the three coefficients
    logic signed [TPR_W:0]   w_prod_t;
    logic signed [TPR_W:0]   w_prod_o;
    logic signed [TPR_W:0]   w_prod_s;
    logic signed [TPR_W-1:0] r_prod_t;
    logic signed [TPR_W-1:0] r_prod_o;
    logic signed [TPR_W-1:0] r_prod_s;
    logic [RAW_W-1:0]        r_d1_1;

    assign w_prod_t = r_dt * $signed({1'b0, r_cal_tcoef});
    assign w_prod_o = r_dt * $signed({1'b0, r_cal_ocoef});
    assign w_prod_s = r_dt * $signed({1'b0, r_cal_scoef});

    // Stage 2: temperature, offset, sensitivity (part-selects are floor shifts)
    logic signed [TEMP_W-1:0] w_temp;
    logic signed [OFF_W-1:0]  w_off;
    logic signed [SENS_W-1:0] w_sens;
    logic signed [TEMP_W-1:0] r_temp_2;
    logic signed [OFF_W-1:0]  r_off_2;
    logic signed [SENS_W-1:0] r_sens_2;
    logic [RAW_W-1:0]         r_d1_2;

    assign w_temp = $signed({r_prod_t[TPR_W-1], r_prod_t[TPR_W-1:23]}) + TEMP_BASE;
    assign w_off  = $signed({r_prod_o[TPR_W-1], r_prod_o[TPR_W-1:7]})
                  + $signed({3'b0, r_cal_poff, 16'b0});
    assign w_sens = $signed({r_prod_s[TPR_W-1], r_prod_s[TPR_W-1:8]})
                  + $signed({3'b0, r_cal_psens, 15'b0});

    // Stage 3: raw pressure times sens, split into two 12-bit halves
    logic signed [PP_W:0]     w_pp_lo;
    logic signed [PP_W:0]     w_pp_hi;
    logic signed [PP_W-1:0]   r_pp_lo;
    logic signed [PP_W-1:0]   r_pp_hi;
    logic signed [OFF_W-1:0]  r_off_3;
    logic signed [TEMP_W-1:0] r_temp_3;

    assign w_pp_lo = $signed({1'b0, r_d1_2[HALF_W-1:0]}) * r_sens_2;
    assign w_pp_hi = $signed({1'b0, r_d1_2[RAW_W-1:HALF_W]}) * r_sens_2;

    // Stage 4: recombine the halves
    logic signed [SUM_W-1:0]  w_sum;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [OFF_W-1:0]  r_off_4;
    logic signed [TEMP_W-1:0] r_temp_4;

    assign w_sum = $signed({r_pp_hi, 12'b0})
                 + $signed({{(SUM_W - PP_W){r_pp_lo[PP_W-1]}}, r_pp_lo});

    // Stage 5: (sum >> 21 - off) >> 15
    logic signed [DIFF_W-1:0]  w_diff;
    logic signed [PRESS_W-1:0] w_press;
    logic signed [TEMP_W-1:0]  r_temp_out;
    logic signed [PRESS_W-1:0] r_press_out;

    assign w_diff  = $signed({r_sum[SUM_W-1], r_sum[SUM_W-1:21]})
                   - $signed({{(DIFF_W - OFF_W){r_off_4[OFF_W-1]}}, r_off_4});
    assign w_press = $signed({w_diff[DIFF_W-1], w_diff[DIFF_W-1:15]});

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_dt   <= w_dt;
            r_d1_0 <= i_pair.raw_pressure;
        end
        if (w_en[1]) begin
            r_prod_t <= w_prod_t[TPR_W-1:0];
            r_prod_o <= w_prod_o[TPR_W-1:0];
            r_prod_s <= w_prod_s[TPR_W-1:0];
            r_d1_1   <= r_d1_0;
        end
        if (w_en[2]) begin
            r_temp_2 <= w_temp;
            r_off_2  <= w_off;
            r_sens_2 <= w_sens;
            r_d1_2   <= r_d1_1;
        end
        if (w_en[3]) begin
            r_pp_lo  <= w_pp_lo[PP_W-1:0];
            r_pp_hi  <= w_pp_hi[PP_W-1:0];
            r_off_3  <= r_off_2;
            r_temp_3 <= r_temp_2;
        end
        if (w_en[4]) begin
            r_sum    <= w_sum;
            r_off_4  <= r_off_3;
            r_temp_4 <= r_temp_3;
        end
        if (w_en[5]) begin
            r_temp_out  <= r_temp_4;
            r_press_out <= w_press;
        end
    end

    assign o_result.valid             = r_v[STAGES-1];
    assign o_result.temperature_centi = r_temp_out;
    assign o_result.pressure_pascal   = r_press_out;

    // Any empty stage must let input in
    a_ready_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(&r_v) |-> i_pair.ready)
        else $error("input not ready although a stage is empty");

    // Full pipeline with a stalled output must block input
    a_block_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_v) && !o_result.ready |-> !i_pair.ready)
        else $error("input ready while pipeline full and stalled");

    // A new result only comes from the stage before it
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_v[STAGES-1]) |-> $past(r_v[STAGES-2]))
        else $error("result appeared without a preceding stage item");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import bpc_pkg::*;

    localparam int WATCHDOG_CYCLES = 5000;
    localparam int HOLD_CYCLES     = 64;
    localparam int SETTLE_CYCLES   = STAGES + 4;
    localparam int RAND_PHASES     = 8;
    localparam int PHASE_ITEMS     = 120;
    localparam int MAX_REPORTS     = 10;

    // indexes past the last calibration word; the block must drop these writes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};
    localparam logic [CAL_W-1:0] CAL_MAX = {CAL_W{1'b1}};

    typedef struct packed {
        logic [TEMP_W-1:0]  temp_centi;
        logic [PRESS_W-1:0] press_pa;
    } t_reading;

    typedef logic [CAL_W-1:0] t_cal_words [6];

    typedef struct {
        int                 cal_set;
        logic [RAW_W-1:0]   raw_p;
        logic [RAW_W-1:0]   raw_t;
        bit                 has_exp;
        logic [TEMP_W-1:0]  exp_temp;
        logic [PRESS_W-1:0] exp_press;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    bpc_in_if  pair_if ();
    bpc_out_if result_if ();

    barometric_pressure_compensation u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_pair     (pair_if),
        .o_result   (result_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // calibration sets used by the directed table, in register order
    t_cal_words cal_sets [5] = '{
        '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
        '{CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX},
        '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312},
        '{16'd0, 16'd0, CAL_MAX, CAL_MAX, CAL_MAX, CAL_MAX},
        '{16'd0, CAL_MAX, 16'd0, 16'd0, 16'd0, 16'd0}
    };

    t_stim_row dir_table [20] = '{
        // reset calibration: temperature is the base, pressure is zero
        '{0, 24'd0,       24'd0,       1'b1, 19'd2000, 24'd0},
        '{0, RAW_MAX,     RAW_MAX,     1'b1, 19'd2000, 24'd0},
        '{0, RAW_MAX,     24'd0,       1'b1, 19'd2000, 24'd0},
        '{0, 24'd0,       RAW_MAX,     1'b1, 19'd2000, 24'd0},
        '{0, 24'h555555,  24'hAAAAAA,  1'b1, 19'd2000, 24'd0},
        '{1, 24'd0,       24'd0,       1'b0, 19'd0, 24'd0},
        '{1, RAW_MAX,     24'd0,       1'b0, 19'd0, 24'd0},
        '{1, 24'd0,       RAW_MAX,     1'b0, 19'd0, 24'd0},
        '{1, RAW_MAX,     RAW_MAX,     1'b0, 19'd0, 24'd0},
        '{1, RAW_MAX,     24'hFFFF00,  1'b0, 19'd0, 24'd0},
        '{2, 24'd9085466, 24'd8569150, 1'b0, 19'd0, 24'd0},
        '{2, 24'd0,       24'd8569150, 1'b0, 19'd0, 24'd0},
        '{2, RAW_MAX,     24'd8569150, 1'b0, 19'd0, 24'd0},
        '{2, 24'd9085466, 24'd0,       1'b0, 19'd0, 24'd0},
        '{2, 24'd9085466, RAW_MAX,     1'b0, 19'd0, 24'd0},
        '{3, RAW_MAX,     24'd0,       1'b0, 19'd0, 24'd0},
        '{3, 24'd0,       24'd0,       1'b0, 19'd0, 24'd0},
        '{3, RAW_MAX,     RAW_MAX,     1'b0, 19'd0, 24'd0},
        // offset base only: pressure is minus twice the word, temperature the base
        '{4, 24'd0,       24'd0,       1'b1, 19'd2000, 24'hFE0002},
        '{4, RAW_MAX,     RAW_MAX,     1'b1, 19'd2000, 24'hFE0002}
    };

    logic [CAL_W-1:0] cal_q [6];
    t_reading         pending_readings [$];
    int               mismatches;
    int               idle_cycles;
    bit               quiet_tail;
    bit               hold_req;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_reading compensate(input logic [RAW_W-1:0] rp,
                                            input logic [RAW_W-1:0] rt);
        longint   d1, d2, dt, temp, off, sens, p;
        t_reading r;
        d1   = longint'({40'd0, rp});
        d2   = longint'({40'd0, rt});
        dt   = d2 - longint'({48'd0, cal_q[CAL_REFERENCE_TEMP]}) * 256;
        temp = 2000 + ((dt * longint'({48'd0, cal_q[CAL_TEMP_COEFF]})) >>> 23);
        off  = longint'({48'd0, cal_q[CAL_PRESSURE_OFFSET]}) * 65536
             + ((longint'({48'd0, cal_q[CAL_OFFSET_TEMP_COEFF]}) * dt) >>> 7);
        sens = longint'({48'd0, cal_q[CAL_PRESSURE_SENSITIVITY]}) * 32768
             + ((longint'({48'd0, cal_q[CAL_SENSITIVITY_TEMP_COEFF]}) * dt) >>> 8);
        p    = (((d1 * sens) >>> 21) - off) >>> 15;
        r.temp_centi = temp[TEMP_W-1:0];
        r.press_pa   = p[PRESS_W-1:0];
        return r;
    endfunction

    function automatic logic [CAL_W-1:0] rand_cal_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return CAL_MAX;
            default: return CAL_W'($urandom);
        endcase
    endfunction

    // mostly full range, some extremes, some readings close to the reference or a typical pressure value
    function automatic logic [RAW_W-1:0] rand_raw(input bit near_ref);
        logic [RAW_W-1:0] base;
        case ($urandom_range(0, 9))
            0: return '0;
            1: return RAW_MAX;
            2, 3: begin
                base = near_ref ? {cal_q[CAL_REFERENCE_TEMP], 8'd0} : 24'd9085466;
                return base + RAW_W'($urandom_range(0, 8191)) - RAW_W'(4096);
            end
            default: return RAW_W'($urandom);
        endcase
    endfunction

    // called and returns at a falling edge
    task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [CAL_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx <= CAL_TEMP_COEFF) begin
            cal_q[idx] = data;
        end
        @(negedge i_clk);
    endtask

    task automatic load_cal(input t_cal_words w);
        write_cal(CAL_PRESSURE_SENSITIVITY, w[CAL_PRESSURE_SENSITIVITY]);
        write_cal(CAL_PRESSURE_OFFSET, w[CAL_PRESSURE_OFFSET]);
        write_cal(CAL_SENSITIVITY_TEMP_COEFF, w[CAL_SENSITIVITY_TEMP_COEFF]);
        write_cal(CAL_OFFSET_TEMP_COEFF, w[CAL_OFFSET_TEMP_COEFF]);
        write_cal(CAL_REFERENCE_TEMP, w[CAL_REFERENCE_TEMP]);
        write_cal(CAL_TEMP_COEFF, w[CAL_TEMP_COEFF]);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        pair_if.valid <= 1'b0;
        while (pending_readings.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_pair(input logic [RAW_W-1:0] rp, input logic [RAW_W-1:0] rt);
        int gap;
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
            pair_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pair_if.valid           <= 1'b1;
        pair_if.raw_pressure    <= rp;
        pair_if.raw_temperature <= rt;
        @(posedge i_clk);
        while (!pair_if.ready) @(posedge i_clk);
        pending_readings.push_back(compensate(rp, rt));
        @(negedge i_clk);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                result_if.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 11);
                result_if.ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                result_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (pending_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected result: temp %h press %h",
                             result_if.temperature_centi, result_if.pressure_pascal);
                end
            end else begin
                want = pending_readings.pop_front();
                if (result_if.temperature_centi !== want.temp_centi ||
                    result_if.pressure_pascal !== want.press_pa) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch: temp exp %h got %h, press exp %h got %h",
                                 want.temp_centi, result_if.temperature_centi,
                                 want.press_pa, result_if.pressure_pascal);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((pair_if.valid && pair_if.ready) || (result_if.valid && result_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_CYCLES) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        int         cur_set;
        t_cal_words words;
        t_reading   got;
        i_rst_n                 = 1'b0;
        cfg_we                  = 1'b0;
        cfg_idx                 = '0;
        cfg_data                = '0;
        pair_if.valid           = 1'b0;
        pair_if.raw_pressure    = '0;
        pair_if.raw_temperature = '0;
        result_if.ready         = 1'b0;
        mismatches              = 0;
        idle_cycles             = 0;
        quiet_tail              = 1'b0;
        hold_req                = 1'b0;
        cur_set                 = -1;
        for (int i = 0; i < 6; i++) cal_q[i] = '0;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_table[r]) begin
            if (dir_table[r].cal_set != cur_set) begin
                drain();
                cur_set = dir_table[r].cal_set;
                if (cur_set == 0) begin
                    // writes past the last index must leave the reset values
                    write_cal(CFG_IDX_SPARE_LO, CAL_MAX);
                    write_cal(CFG_IDX_SPARE_HI, CAL_MAX);
                    cfg_we <= 1'b0;
                end else begin
                    load_cal(cal_sets[cur_set]);
                end
            end
            if (dir_table[r].has_exp) begin
                got = compensate(dir_table[r].raw_p, dir_table[r].raw_t);
                if (got.temp_centi !== dir_table[r].exp_temp ||
                    got.press_pa !== dir_table[r].exp_press) begin
                    $display("table row %0d: predictor disagrees", r);
                end
                // the typed value is what the block is held to
                got.temp_centi = dir_table[r].exp_temp;
                got.press_pa   = dir_table[r].exp_press;
            end
            send_pair(dir_table[r].raw_p, dir_table[r].raw_t);
            if (dir_table[r].has_exp) begin
                pending_readings[pending_readings.size() - 1] = got;
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            drain();
            quiet_tail = (ph == RAND_PHASES - 1);
            for (int w = 0; w < 6; w++) words[w] = rand_cal_word();
            load_cal(words);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (ph == 1 && k == 30) hold_req = 1'b1;
                send_pair(rand_raw(1'b0), rand_raw(1'b1));
            end
        end

        drain();
        if (mismatches == 0 && pending_readings.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_in_if.sv
hw/rtl/bpc_out_if.sv
hw/rtl/barometric_pressure_compensation.sv
tb/tb.sv
